// ===== rtl/core/scft_pkg.sv =====
// Shared types, register codes and defaults for the sphere/cone frustum test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scft_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int UNIT_BITS     = 16;
  localparam int ADDR_W        = 5;

  localparam logic [2:0] REG_NEAR  = 3'd0;
  localparam logic [2:0] REG_FAR   = 3'd1;
  localparam logic [2:0] REG_SINE  = 3'd2;
  localparam logic [2:0] REG_INVC  = 3'd3;
  localparam logic [2:0] REG_WIDTH = 3'd4;
  localparam logic [2:0] REG_HGT   = 3'd5;
  localparam logic [2:0] REG_CLIP  = 3'd6;

  localparam logic [31:0] NEAR_RST  = 32'd0;
  localparam logic [31:0] FAR_RST   = 32'd65536000;
  localparam logic [16:0] SINE_RST  = 17'd32768;
  localparam logic [24:0] INVC_RST  = 25'd75674;
  localparam logic [12:0] WIDTH_RST = 13'd640;
  localparam logic [12:0] HGT_RST   = 13'd480;
  localparam logic [24:0] CLIP_RST  = 25'd65536;

  typedef struct packed {
    logic               busy;
    logic        [30:0] tanw;
    logic        [31:0] sec;
  } derived_t;

  typedef struct packed {
    logic        [62:0] dsq;
    logic signed [31:0] depth;
    logic signed [31:0] radius;
    logic               cc;
  } front_t;

endpackage
`default_nettype wire

// ===== rtl/core/sphere_cone_frustum_test.sv =====
// Top level: APB register file, derived-constant sequencer and 9-stage test pipeline.
// Depends on scft_pkg, scft_cfg, scft_front, scft_back.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata 280b, tuser camera_clip
//  out_    | out | tvalid/tready      | tdata 8b, visible in bit 0
//  cfg_    | in  | psel/penable/pready| 7 registers, 32b at 4*i
//
// One transaction per cycle while the output is free and the sequencer is idle.
// A stalled output freezes the whole pipeline; nothing is dropped.
// After reset and after every register write the tangent/secant sequencer runs
// a 31-step divide and a 32-step square root; in_tready is low meanwhile.
// Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module sphere_cone_frustum_test #(
  parameter int FRAC_BITS = scft_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, apex_x, apex_y, apex_z,
  // axis_x, axis_y, axis_z, zero pad
  input  wire                  [279:0] in_tdata,
  // camera_clip
  input  wire                          in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // visible, zero pad
  output logic                   [7:0] out_tdata,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [scft_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire                   [31:0] cfg_pwdata,
  output logic                  [31:0] cfg_prdata,
  output logic                         cfg_pready
);

  logic [31:0] near_r, far_r;
  logic [16:0] sine_r;
  logic [24:0] invc_r, clip_r;
  logic [12:0] width_r, hgt_r;
  logic        wr;
  logic [2:0]  idx;
  logic        en;
  logic        fv, bv, vis;

  scft_pkg::derived_t drv;
  scft_pkg::front_t   fo;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r  <= scft_pkg::NEAR_RST;
      far_r   <= scft_pkg::FAR_RST;
      sine_r  <= scft_pkg::SINE_RST;
      invc_r  <= scft_pkg::INVC_RST;
      width_r <= scft_pkg::WIDTH_RST;
      hgt_r   <= scft_pkg::HGT_RST;
      clip_r  <= scft_pkg::CLIP_RST;
    end else if (wr) begin
      case (idx)
        scft_pkg::REG_NEAR:  near_r  <= cfg_pwdata;
        scft_pkg::REG_FAR:   far_r   <= cfg_pwdata;
        scft_pkg::REG_SINE:  sine_r  <= cfg_pwdata[16:0];
        scft_pkg::REG_INVC:  invc_r  <= cfg_pwdata[24:0];
        scft_pkg::REG_WIDTH: width_r <= cfg_pwdata[12:0];
        scft_pkg::REG_HGT:   hgt_r   <= cfg_pwdata[12:0];
        scft_pkg::REG_CLIP:  clip_r  <= cfg_pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      scft_pkg::REG_NEAR:  cfg_prdata = near_r;
      scft_pkg::REG_FAR:   cfg_prdata = far_r;
      scft_pkg::REG_SINE:  cfg_prdata = 32'(sine_r);
      scft_pkg::REG_INVC:  cfg_prdata = 32'(invc_r);
      scft_pkg::REG_WIDTH: cfg_prdata = 32'(width_r);
      scft_pkg::REG_HGT:   cfg_prdata = 32'(hgt_r);
      scft_pkg::REG_CLIP:  cfg_prdata = 32'(clip_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign en        = !bv || out_tready;
  assign in_tready = en && !drv.busy;

  scft_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (wr),
    .width  (width_r),
    .height (hgt_r),
    .sine   (sine_r),
    .invc   (invc_r),
    .drv    (drv)
  );

  scft_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vin   (in_tvalid && in_tready),
    .data  (in_tdata),
    .cc_in (in_tuser),
    .vout  (fv),
    .fo    (fo)
  );

  scft_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vin        (fv),
    .fi         (fo),
    .drv        (drv),
    .near_plane (near_r),
    .far_plane  (far_r),
    .clip_scale (clip_r),
    .vout       (bv),
    .visible    (vis)
  );

  assign out_tvalid = bv;
  assign out_tdata  = {7'd0, vis};

endmodule
`default_nettype wire

// ===== rtl/core/scft_cfg.sv =====
// Sequencer deriving widened cone tangent and secant from the config registers.
// Depends on scft_pkg. Serial divider and serial square root, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module scft_cfg (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr,
  input  wire         [12:0] width,
  input  wire         [12:0] height,
  input  wire         [16:0] sine,
  input  wire         [24:0] invc,
  output scft_pkg::derived_t drv
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL0 = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_SQ   = 6'b010000,
    ST_SQRT = 6'b100000
  } state_t;

  state_t        state_r;
  logic          start_r;
  logic   [30:0] num_r;
  logic   [14:0] den_r;
  logic   [14:0] rem_r;
  logic   [30:0] quo_r;
  logic   [30:0] scale_r;
  logic   [25:0] tan0_r;
  logic   [30:0] tanw_r;
  logic   [63:0] rad_r;
  logic   [34:0] srem_r;
  logic   [31:0] root_r;
  logic   [31:0] sec_r;
  logic   [4:0]  cnt_r;

  logic   [15:0] rem_sh;
  logic          qbit;
  logic   [14:0] rem_nxt;
  logic   [30:0] quo_nxt;
  logic   [41:0] p0;
  logic   [56:0] p1;
  logic   [34:0] srem_sh;
  logic   [34:0] trial;
  logic          sbit;
  logic   [34:0] srem_nxt;
  logic   [31:0] root_nxt;

  always_comb begin
    rem_sh   = {rem_r, num_r[30]};
    qbit     = rem_sh >= {1'b0, den_r};
    rem_nxt  = qbit ? 15'(rem_sh - {1'b0, den_r}) : rem_sh[14:0];
    quo_nxt  = {quo_r[29:0], qbit};
    p0       = sine * invc;
    p1       = tan0_r * scale_r;
    srem_sh  = {srem_r[32:0], rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    sbit     = srem_sh >= trial;
    srem_nxt = sbit ? srem_sh - trial : srem_sh;
    root_nxt = {root_r[30:0], sbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b1;
    end else begin
      if (cfg_wr) start_r <= 1'b1;
      case (state_r)
        ST_IDLE: begin
          if (start_r && !cfg_wr) begin
            start_r <= 1'b0;
            num_r   <= {15'(3 * width), 16'd0};
            den_r   <= {height, 2'b00};
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= 5'd30;
            if (height == '0) begin
              scale_r <= 31'(1) << scft_pkg::UNIT_BITS;
              state_r <= ST_MUL0;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          num_r <= {num_r[29:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            scale_r <= (quo_nxt < (31'(1) << scft_pkg::UNIT_BITS)) ?
                       (31'(1) << scft_pkg::UNIT_BITS) : quo_nxt;
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          tan0_r  <= p0[41:16];
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          tanw_r  <= (p1[56:16] > 41'h7FFFFFFF) ? 31'h7FFFFFFF : p1[46:16];
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          rad_r   <= 64'(tanw_r) * 64'(tanw_r) + (64'd1 << 32);
          srem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= 5'd31;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          rad_r  <= {rad_r[61:0], 2'b00};
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            sec_r   <= root_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign drv.busy = start_r || (state_r != ST_IDLE);
  assign drv.tanw = tanw_r;
  assign drv.sec  = sec_r;

endmodule
`default_nettype wire

// ===== rtl/core/scft_front.sv =====
// Front pipeline: offsets, squared distance and depth along the axis (3 stages).
// Depends on scft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scft_front #(
  parameter int FRAC_BITS = scft_pkg::FRAC_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  wire              vin,
  input  wire      [279:0] data,
  input  wire              cc_in,
  output logic             vout,
  output scft_pkg::front_t fo
);

  localparam logic signed [33:0] TWO = 34'sd2 <<< FRAC_BITS;
  localparam logic signed [33:0] TEN = 34'sd10 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat30(input logic signed [51:0] v);
    if (v > 52'sd1073741824) return 32'sd1073741824;
    if (v < -52'sd1073741824) return -32'sd1073741824;
    return v[31:0];
  endfunction

  logic signed [31:0] sx, sy, sz, sr, px, py, pz;
  logic signed [17:0] ax, ay, az;
  logic signed [33:0] tzw;
  logic               adj;

  logic               v1_r, v2_r, v3_r;
  logic signed [31:0] dx_r, dy_r, tz_r, r1_r, r2_r;
  logic signed [17:0] ax_r, ay_r, az_r;
  logic               cc1_r, cc2_r;
  logic signed [49:0] mx_r, my_r, mz_r;
  logic signed [61:0] qx_r, qy_r, qz_r;
  scft_pkg::front_t   fo_r;
  logic signed [63:0] dsq_sum;
  logic signed [51:0] dep_sum;

  always_comb begin
    sx  = data[31:0];    sy = data[63:32];   sz = data[95:64];   sr = data[127:96];
    px  = data[159:128]; py = data[191:160]; pz = data[223:192];
    ax  = data[241:224]; ay = data[259:242]; az = data[277:260];
    adj = cc_in && (34'(sr) > TWO) && (34'(sr) < TEN);
    tzw = 34'(sz) - 34'(pz) + (adj ? 34'(sr) : 34'sd0);
    dsq_sum = 64'(qx_r) + 64'(qy_r) + 64'(qz_r);
    dep_sum = -(52'(mx_r) + 52'(my_r) + 52'(mz_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vin;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= sat30(52'(33'(sx) - 33'(px)));
      dy_r  <= sat30(52'(33'(sy) - 33'(py)));
      tz_r  <= sat30(52'(tzw));
      ax_r  <= ax;
      ay_r  <= ay;
      az_r  <= az;
      r1_r  <= sr;
      cc1_r <= cc_in;
      mx_r  <= dx_r * ax_r;
      my_r  <= dy_r * ay_r;
      mz_r  <= tz_r * az_r;
      qx_r  <= dx_r * dx_r;
      qy_r  <= dy_r * dy_r;
      qz_r  <= tz_r * tz_r;
      r2_r  <= r1_r;
      cc2_r <= cc1_r;
      fo_r.dsq    <= dsq_sum[62:0];
      fo_r.depth  <= sat30(dep_sum >>> scft_pkg::UNIT_BITS);
      fo_r.radius <= r2_r;
      fo_r.cc     <= cc2_r;
    end
  end

  assign vout = v3_r;
  assign fo   = fo_r;

endmodule
`default_nettype wire

// ===== rtl/core/scft_back.sv =====
// Back pipeline: depth window, cone radius, inside and camera-clip tests (6 stages).
// Depends on scft_pkg. Last stage is the output register.
`timescale 1ns / 1ps
`default_nettype none
module scft_back #(
  parameter int FRAC_BITS = scft_pkg::FRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                vin,
  input  scft_pkg::front_t   fi,
  input  scft_pkg::derived_t drv,
  input  wire signed  [31:0] near_plane,
  input  wire signed  [31:0] far_plane,
  input  wire         [24:0] clip_scale,
  output logic               vout,
  output logic               visible
);

  localparam logic signed [33:0] TEN  = 34'sd10 <<< FRAC_BITS;
  localparam logic signed [33:0] FIVE = 34'sd5 <<< FRAC_BITS;

  logic               v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  // stage 4
  logic        [62:0] dsq4_r;
  logic signed [31:0] r4_r;
  logic               cc4_r, zero4_r, rng4_r;
  logic signed [63:0] pdt_r;
  logic signed [64:0] prs_r;
  logic        [61:0] dd_r;
  // stage 5
  logic        [62:0] dsq5_r;
  logic signed [31:0] r5_r;
  logic               cc5_r, zero5_r, rng5_r;
  logic        [31:0] c1_r;
  logic        [38:0] c2_r;
  logic signed [64:0] rad5_r;
  // stage 6
  logic        [62:0] dsq6_r;
  logic signed [31:0] r6_r;
  logic               cc6_r, zero6_r, rng6_r;
  logic        [63:0] c1sq_r, c2s_r;
  logic signed [64:0] rad6_r;
  // stage 7
  logic        [62:0] dsq7_r;
  logic               cc7_r, zero7_r, rng7_r, in7_r, big7_r;
  logic        [31:0] sc_r;
  logic signed [33:0] rb_r;
  logic signed [64:0] rad7_r;
  // stage 8
  logic        [62:0] dsq8_r;
  logic               cc8_r, zero8_r, rng8_r, in8_r, big8_r, rpos_r;
  logic        [63:0] scsq_r;
  logic signed [67:0] rr_r;
  logic signed [64:0] rad8_r;
  logic               vis_r;

  logic signed [33:0] d33, lo, hi;
  logic signed [65:0] crs, cr;
  logic        [49:0] acr;
  logic        [47:0] sc_w;
  logic               inner, dge, vis_nxt;

  always_comb begin
    d33  = 34'(fi.depth);
    lo   = 34'(near_plane) - 34'(fi.radius);
    hi   = 34'(far_plane) + 34'(fi.radius);
    crs  = 66'(pdt_r) + 66'(prs_r);
    cr   = crs >>> scft_pkg::UNIT_BITS;
    acr  = cr[65] ? 50'(-cr) : cr[49:0];
    sc_w = c2s_r[63:16];
    inner = $signed({1'b0, scsq_r}) > rad8_r;
    dge   = {5'd0, dsq8_r} >= rr_r[67:0];
    if (zero8_r)                 vis_nxt = 1'b1;
    else if (!rng8_r || !in8_r)  vis_nxt = 1'b0;
    else if (!cc8_r)             vis_nxt = 1'b1;
    else if (!big8_r && inner)   vis_nxt = 1'b1;
    else if (!rpos_r)            vis_nxt = 1'b1;
    else                         vis_nxt = dge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v4_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= '0;
    end else if (en) begin
      {v4_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= {vin, v4_r, v5_r, v6_r, v7_r, v8_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq4_r  <= fi.dsq;
      r4_r    <= fi.radius;
      cc4_r   <= fi.cc;
      zero4_r <= fi.dsq == '0;
      rng4_r  <= (lo <= d33) && (d33 <= hi);
      pdt_r   <= fi.depth * $signed({1'b0, drv.tanw});
      prs_r   <= fi.radius * $signed({1'b0, drv.sec});
      dd_r    <= 62'(64'(fi.depth) * 64'(fi.depth));

      dsq5_r  <= dsq4_r;
      r5_r    <= r4_r;
      cc5_r   <= cc4_r;
      zero5_r <= zero4_r;
      rng5_r  <= rng4_r;
      c1_r    <= (acr > 50'h80000000) ? 32'h80000000 : acr[31:0];
      c2_r    <= (acr > (50'd1 << 38)) ? (39'd1 << 38) : acr[38:0];
      rad5_r  <= $signed({2'b00, dsq4_r}) - $signed({3'b000, dd_r});

      dsq6_r  <= dsq5_r;
      r6_r    <= r5_r;
      cc6_r   <= cc5_r;
      zero6_r <= zero5_r;
      rng6_r  <= rng5_r;
      c1sq_r  <= c1_r * c1_r;
      c2s_r   <= c2_r * clip_scale;
      rad6_r  <= rad5_r;

      dsq7_r  <= dsq6_r;
      cc7_r   <= cc6_r;
      zero7_r <= zero6_r;
      rng7_r  <= rng6_r;
      in7_r   <= $signed({1'b0, c1sq_r}) > rad6_r;
      big7_r  <= 34'(r6_r) >= TEN;
      rb_r    <= (34'(r6_r) >= TEN) ? 34'(r6_r) + FIVE : 34'(r6_r);
      sc_r    <= (sc_w > 48'h80000000) ? 32'h80000000 : sc_w[31:0];
      rad7_r  <= rad6_r;

      dsq8_r  <= dsq7_r;
      cc8_r   <= cc7_r;
      zero8_r <= zero7_r;
      rng8_r  <= rng7_r;
      in8_r   <= in7_r;
      big8_r  <= big7_r;
      rpos_r  <= rb_r > 34'sd0;
      scsq_r  <= sc_r * sc_r;
      rr_r    <= rb_r * rb_r;
      rad8_r  <= rad7_r;

      vis_r   <= vis_nxt;
    end
  end

  assign vout    = v9_r;
  assign visible = vis_r;

endmodule
`default_nettype wire

// ===== rtl/core/scft_checker.sv =====
// Port-level checks for sphere_cone_frustum_test, attached by bind.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scft_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_tready,
  input wire                         out_tvalid,
  input wire                         out_tready,
  input wire                   [7:0] out_tdata,
  input wire                         cfg_psel,
  input wire                         cfg_penable,
  input wire                         cfg_pwrite,
  input wire                         cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out transaction dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("out data changed");

  a_wr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready |=> !in_tready)
    else $error("input accepted during recompute");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("input taken while stalled");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0) else $error("out pad bits set");

endmodule

bind sphere_cone_frustum_test scft_checker u_scft_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready)
);
`default_nettype wire
